### rtl/core/lps_pkg.sv
// Shared constants, types and codes of the LED pattern sequencer.
package lps_pkg;

    localparam int PROGRAM_BYTES   = 1024;
    localparam int LEDS_PER_FRAME  = 13;
    localparam int COLOR_ADDR_BITS = 20;

    localparam int ADDR_BITS      = $clog2(PROGRAM_BYTES);
    localparam int LOAD_ADDR_BITS = 10;
    localparam int POS_BITS       = (LEDS_PER_FRAME > 1) ? $clog2(LEDS_PER_FRAME) : 1;

    typedef logic [ADDR_BITS-1:0]       t_addr;
    typedef logic [COLOR_ADDR_BITS-1:0] t_color;
    typedef logic [POS_BITS-1:0]        t_pos;
    typedef logic [15:0]                t_word;
    typedef logic [7:0]                 t_byte;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_SECOND = 2'd1,
        CMD_START  = 2'd2,
        CMD_LOAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_ILLUM   = 2'd0,
        OP_PAUSE   = 2'd1,
        OP_SLEEP   = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    localparam logic [1:0] STAT_NONE  = 2'd0;
    localparam logic [1:0] STAT_COLOR = 2'd1;
    localparam logic [1:0] STAT_HALT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TAKE,
        S_EMIT,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        FX_OP,
        FX_N_LO,
        FX_N_HI,
        FX_B_LO,
        FX_B_HI
    } t_fidx;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        t_addr raddr;
    } t_store_req;

endpackage

### rtl/core/led_pattern_sequencer.sv
// Top level of the LED pattern sequencer: instruction fetch sequencer and frame emitter.
//
//  channel | handshake          | fields
//  --------+--------------------+--------------------------------------------------
//  input   | i_valid / o_stall  | i_opcode, i_load_address, i_load_byte
//  output  | o_valid / i_stall  | o_color_address, o_led_position, o_led_power,
//          |                    | o_status, o_last
//
// One word at a time. A load or an ignored tick gives one result word, held by i_stall.
// Each fetched byte passes S_READ and S_TAKE at the registered store read port; an
// instruction is one to five bytes, six with a restart. A lit frame emits LEDS_PER_FRAME
// words at one per cycle unless i_stall holds, then fetches if the illuminate ends.
// i_stall holds the current word; o_stall is high whenever an item is in work.
// Reset clears the sequencer and all counters; the store is not cleared.
module led_pattern_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_opcode,
    input  logic [lps_pkg::LOAD_ADDR_BITS-1:0]   i_load_address,
    input  logic [7:0]                           i_load_byte,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [lps_pkg::COLOR_ADDR_BITS-1:0]  o_color_address,
    output logic [lps_pkg::POS_BITS-1:0]         o_led_position,
    output logic                                 o_led_power,
    output logic [1:0]                           o_status,
    output logic                                 o_last
);

    lps_pkg::t_state r_state, n_state;
    lps_pkg::t_fidx  r_fidx, n_fidx;
    lps_pkg::t_addr  r_pc, n_pc;
    logic [1:0]      r_op, n_op;
    lps_pkg::t_word  r_done, n_done;
    lps_pkg::t_word  r_target, n_target;
    lps_pkg::t_color r_color_base, n_color_base;
    lps_pkg::t_word  r_pause, n_pause;
    lps_pkg::t_word  r_sleep, n_sleep;
    logic            r_power, n_power;
    logic            r_halted, n_halted;
    logic            r_restarted, n_restarted;
    logic            r_quiet, n_quiet;
    lps_pkg::t_pos   r_pos, n_pos;
    lps_pkg::t_byte  r_lo, n_lo;

    lps_pkg::t_store_req store_req;
    lps_pkg::t_byte      rdata;
    lps_pkg::t_addr      pc_inc;
    lps_pkg::t_word      done_inc;
    lps_pkg::t_cmd       cmd;
    logic                accept;
    logic                out_fire;

    lps_store u_store (
        .i_clk  (i_clk),
        .i_req  (store_req),
        .o_rdata(rdata)
    );

    assign cmd      = lps_pkg::t_cmd'(i_opcode);
    assign accept   = i_valid && (r_state == lps_pkg::S_IDLE);
    assign out_fire = o_valid && !i_stall;
    assign pc_inc   = (r_pc == lps_pkg::t_addr'(lps_pkg::PROGRAM_BYTES - 1)) ?
                      '0 : r_pc + lps_pkg::t_addr'(1);
    assign done_inc = r_done + 16'd1;

    always_comb begin
        n_state      = r_state;
        n_fidx       = r_fidx;
        n_pc         = r_pc;
        n_op         = r_op;
        n_done       = r_done;
        n_target     = r_target;
        n_color_base = r_color_base;
        n_pause      = r_pause;
        n_sleep      = r_sleep;
        n_power      = r_power;
        n_halted     = r_halted;
        n_restarted  = r_restarted;
        n_quiet      = r_quiet;
        n_pos        = r_pos;
        n_lo         = r_lo;
        case (r_state)
            lps_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = lps_pkg::S_RESULT;
                    n_fidx  = lps_pkg::FX_OP;
                    n_restarted = 1'b0;
                    n_quiet = 1'b0;
                    case (cmd)
                        lps_pkg::CMD_START: begin
                            n_pc         = '0;
                            n_done       = '0;
                            n_target     = '0;
                            n_color_base = '0;
                            n_pause      = '0;
                            n_sleep      = '0;
                            n_halted     = 1'b0;
                            n_state      = lps_pkg::S_READ;
                        end
                        lps_pkg::CMD_SECOND: begin
                            if (!r_halted && r_op == lps_pkg::OP_SLEEP) begin
                                if (r_sleep <= 16'd1) begin
                                    n_sleep = '0;
                                    n_state = lps_pkg::S_READ;
                                end else begin
                                    n_sleep = r_sleep - 16'd1;
                                end
                            end
                        end
                        lps_pkg::CMD_FRAME: begin
                            if (!r_halted && r_power) begin
                                if (r_op == lps_pkg::OP_ILLUM) begin
                                    n_pos   = '0;
                                    n_state = lps_pkg::S_EMIT;
                                end else if (r_op == lps_pkg::OP_PAUSE) begin
                                    if (r_pause == '0) begin
                                        n_state = lps_pkg::S_READ;
                                    end else begin
                                        n_pause = r_pause - 16'd1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lps_pkg::S_READ: begin
                n_pc    = pc_inc;
                n_state = lps_pkg::S_TAKE;
            end
            lps_pkg::S_TAKE: begin
                n_state = lps_pkg::S_READ;
                case (r_fidx)
                    lps_pkg::FX_OP: begin
                        if (rdata[7:2] != '0) begin
                            n_halted = 1'b1;
                            n_state  = r_quiet ? lps_pkg::S_IDLE : lps_pkg::S_RESULT;
                        end else begin
                            n_op = rdata[1:0];
                            if (rdata[1:0] == lps_pkg::OP_RESTART) begin
                                if (r_restarted) begin
                                    n_halted = 1'b1;
                                    n_state  = r_quiet ? lps_pkg::S_IDLE : lps_pkg::S_RESULT;
                                end else begin
                                    n_restarted  = 1'b1;
                                    n_pc         = '0;
                                    n_done       = '0;
                                    n_target     = '0;
                                    n_color_base = '0;
                                    n_pause      = '0;
                                    n_sleep      = '0;
                                end
                            end else begin
                                n_fidx = lps_pkg::FX_N_LO;
                            end
                        end
                    end
                    lps_pkg::FX_N_LO: begin
                        n_lo   = rdata;
                        n_fidx = lps_pkg::FX_N_HI;
                    end
                    lps_pkg::FX_N_HI: begin
                        case (r_op)
                            lps_pkg::OP_ILLUM: begin
                                n_done   = '0;
                                n_target = {rdata, r_lo};
                                n_fidx   = lps_pkg::FX_B_LO;
                            end
                            lps_pkg::OP_PAUSE: begin
                                n_pause = {rdata, r_lo};
                                n_state = r_quiet ? lps_pkg::S_IDLE : lps_pkg::S_RESULT;
                            end
                            default: begin
                                n_sleep = {rdata, r_lo};
                                n_power = 1'b0;
                                n_state = r_quiet ? lps_pkg::S_IDLE : lps_pkg::S_RESULT;
                            end
                        endcase
                    end
                    lps_pkg::FX_B_LO: begin
                        n_lo   = rdata;
                        n_fidx = lps_pkg::FX_B_HI;
                    end
                    default: begin
                        n_color_base = lps_pkg::t_color'({rdata, r_lo});
                        n_power      = 1'b1;
                        n_state      = r_quiet ? lps_pkg::S_IDLE : lps_pkg::S_RESULT;
                    end
                endcase
            end
            lps_pkg::S_EMIT: begin
                if (out_fire) begin
                    if (r_pos == lps_pkg::t_pos'(lps_pkg::LEDS_PER_FRAME - 1)) begin
                        n_color_base = r_color_base +
                                       lps_pkg::t_color'(lps_pkg::LEDS_PER_FRAME);
                        n_done = done_inc;
                        if (done_inc >= r_target) begin
                            n_state     = lps_pkg::S_READ;
                            n_fidx      = lps_pkg::FX_OP;
                            n_restarted = 1'b0;
                            n_quiet     = 1'b1;
                        end else begin
                            n_state = lps_pkg::S_IDLE;
                        end
                    end else begin
                        n_pos = r_pos + lps_pkg::t_pos'(1);
                    end
                end
            end
            lps_pkg::S_RESULT: begin
                if (out_fire) begin
                    n_state = lps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall           = (r_state != lps_pkg::S_IDLE);
        store_req.we      = accept && (cmd == lps_pkg::CMD_LOAD);
        store_req.waddr   = lps_pkg::t_addr'(i_load_address);
        store_req.wdata   = i_load_byte;
        store_req.raddr   = r_pc;
        o_valid           = 1'b0;
        o_color_address   = '0;
        o_led_position    = '0;
        o_led_power       = r_power;
        o_status          = r_halted ? lps_pkg::STAT_HALT : lps_pkg::STAT_NONE;
        o_last            = 1'b1;
        case (r_state)
            lps_pkg::S_EMIT: begin
                o_valid         = 1'b1;
                o_color_address = r_color_base + lps_pkg::t_color'(r_pos);
                o_led_position  = r_pos;
                o_led_power     = 1'b1;
                o_status        = lps_pkg::STAT_COLOR;
                o_last          = (r_pos == lps_pkg::t_pos'(lps_pkg::LEDS_PER_FRAME - 1));
            end
            lps_pkg::S_RESULT: begin
                o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lps_pkg::S_IDLE;
            r_fidx       <= lps_pkg::FX_OP;
            r_pc         <= '0;
            r_op         <= lps_pkg::OP_ILLUM;
            r_done       <= '0;
            r_target     <= '0;
            r_color_base <= '0;
            r_pause      <= '0;
            r_sleep      <= '0;
            r_power      <= 1'b0;
            r_halted     <= 1'b0;
            r_restarted  <= 1'b0;
            r_quiet      <= 1'b0;
            r_pos        <= '0;
        end else begin
            r_state      <= n_state;
            r_fidx       <= n_fidx;
            r_pc         <= n_pc;
            r_op         <= n_op;
            r_done       <= n_done;
            r_target     <= n_target;
            r_color_base <= n_color_base;
            r_pause      <= n_pause;
            r_sleep      <= n_sleep;
            r_power      <= n_power;
            r_halted     <= n_halted;
            r_restarted  <= n_restarted;
            r_quiet      <= n_quiet;
            r_pos        <= n_pos;
        end
        r_lo <= n_lo;
    end

endmodule

### rtl/core/lps_store.sv
// Program byte store with one write port and one registered read port.
module lps_store (
    input  logic               i_clk,
    input  lps_pkg::t_store_req i_req,
    output lps_pkg::t_byte     o_rdata
);

    lps_pkg::t_byte r_mem [lps_pkg::PROGRAM_BYTES];
    lps_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
